FILE: rtl/core/postfix_expression_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the postfix expression evaluator
// Clocked implication helpers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFXE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFXE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pfxe_pkg.sv
// ----------------------------------------------------------------------------
// pfxe_pkg
// Shared types, character codes and status codes of the postfix evaluator.
// ----------------------------------------------------------------------------
package pfxe_pkg;

  localparam int DATA_W          = 32;
  localparam int STACK_DEPTH_DEF = 128;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [1:0] STAT_DIVZERO   = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_TERM
  } op_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [2:0] {
    AP_IDLE,
    AP_ABS_A,
    AP_ABS_B,
    AP_ITER,
    AP_FIX,
    AP_DONE
  } alu_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP_R,
    ST_RD_R,
    ST_POP_L,
    ST_RD_L,
    ST_EXEC,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

  function automatic op_t decode_char(input logic [7:0] ch);
    op_t op;
    op = OP_NONE;
    if (ch >= CH_ZERO && ch <= CH_NINE) op = OP_DIGIT;
    else if (ch == CH_PLUS)             op = OP_ADD;
    else if (ch == CH_MINUS)            op = OP_SUB;
    else if (ch == CH_STAR)             op = OP_MUL;
    else if (ch == CH_SLASH)            op = OP_DIV;
    else if (ch == CH_CLOSE)            op = OP_TERM;
    return op;
  endfunction

  function automatic alu_op_t alu_op_of(input op_t op);
    alu_op_t a;
    case (op)
      OP_SUB:  a = ALU_SUB;
      OP_MUL:  a = ALU_MUL;
      OP_DIV:  a = ALU_DIV;
      default: a = ALU_ADD;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Reverse Polish evaluator over ASCII characters on a 32-bit operand stack.
// ----------------------------------------------------------------------------
// One character is taken per input transfer. A digit pushes its value, an
// operator + - * / pops the right then the left operand and pushes the
// wrapping 32-bit result (division truncates toward zero), ')' pops the top
// and emits it with the expression status, then clears stack and status;
// any other character is dropped. Status keeps the first error of the
// expression: 1 overflow (push on full stack, value dropped), 2 underflow
// (pop on empty stack reads zero), 3 divide by zero (result zero). Items
// are handled one at a time and in_stall is high while one is at work.
// ')' waits while the result register is held by out_stall. Multiply and
// divide run 32 iterations of the shared 33-bit adder in pfxe_alu, and
// divide first forms the operand magnitudes; stack reads go through the
// registered RAM read port. The result register lets new characters flow
// in while an emitted result still waits to be taken.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfxe_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_value,
  output logic [1:0]  out_status
);

  localparam int W  = pfxe_pkg::DATA_W;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  pfxe_pkg::state_t state_r, state_nxt;
  pfxe_pkg::op_t    op_r, op_nxt;
  logic [DW-1:0]    depth_r, depth_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [W-1:0]     right_r, right_nxt;
  logic [W-1:0]     left_r, left_nxt;
  logic [W-1:0]     push_data_r, push_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [W-1:0]     out_value_r, out_value_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  pfxe_pkg::op_t      in_op;
  pfxe_pkg::alu_req_t alu_req;
  pfxe_pkg::alu_rsp_t alu_rsp;
  logic [W-1:0]       alu_result;
  logic [DW-1:0]      depth_m1;
  logic               ram_we;
  logic [W-1:0]       ram_rdata;

  assign in_op    = pfxe_pkg::decode_char(in_char_code);
  assign depth_m1 = depth_r - 1'b1;

  // Operand stack storage: push at depth, pop from depth - 1
  pfxe_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (depth_r[AW-1:0]),
    .wr_data (push_data_r),
    .rd_addr (depth_m1[AW-1:0]),
    .rd_data (ram_rdata)
  );

  pfxe_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opd_a  (left_r),
    .opd_b  (right_r),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfxe_pkg::ST_IDLE;
      depth_r     <= '0;
      err_r       <= pfxe_pkg::STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    right_r      <= right_nxt;
    left_r       <= left_nxt;
    push_data_r  <= push_data_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    depth_nxt      = depth_r;
    err_nxt        = err_r;
    right_nxt      = right_r;
    left_nxt       = left_r;
    push_data_nxt  = push_data_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    alu_req.start  = 1'b0;
    alu_req.op     = pfxe_pkg::alu_op_of(op_r);

    // Retire the held result once the consumer takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pfxe_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;
          case (in_op)
            pfxe_pkg::OP_DIGIT: begin
              // Low nibble of '0'..'9' is the digit value
              push_data_nxt = W'(in_char_code[3:0]);
              state_nxt     = pfxe_pkg::ST_PUSH;
            end
            pfxe_pkg::OP_ADD, pfxe_pkg::OP_SUB, pfxe_pkg::OP_MUL,
            pfxe_pkg::OP_DIV, pfxe_pkg::OP_TERM: begin
              state_nxt = pfxe_pkg::ST_POP_R;
            end
            default: begin
              state_nxt = pfxe_pkg::ST_IDLE;
            end
          endcase
        end
      end
      pfxe_pkg::ST_PUSH: begin
        if (depth_r == FULL) begin
          // Drop the value on a full stack
          if (err_r == pfxe_pkg::STAT_OK) err_nxt = pfxe_pkg::STAT_OVERFLOW;
        end else begin
          ram_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
        end
        state_nxt = pfxe_pkg::ST_IDLE;
      end
      pfxe_pkg::ST_POP_R: begin
        if (depth_r == '0) begin
          // Empty stack: pop reads as zero
          if (err_r == pfxe_pkg::STAT_OK) err_nxt = pfxe_pkg::STAT_UNDERFLOW;
          right_nxt = '0;
          state_nxt = (op_r == pfxe_pkg::OP_TERM) ? pfxe_pkg::ST_EMIT
                                                  : pfxe_pkg::ST_POP_L;
        end else begin
          depth_nxt = depth_m1;
          state_nxt = pfxe_pkg::ST_RD_R;
        end
      end
      pfxe_pkg::ST_RD_R: begin
        right_nxt = ram_rdata;
        state_nxt = (op_r == pfxe_pkg::OP_TERM) ? pfxe_pkg::ST_EMIT
                                                : pfxe_pkg::ST_POP_L;
      end
      pfxe_pkg::ST_POP_L: begin
        if (depth_r == '0) begin
          if (err_r == pfxe_pkg::STAT_OK) err_nxt = pfxe_pkg::STAT_UNDERFLOW;
          left_nxt  = '0;
          state_nxt = pfxe_pkg::ST_EXEC;
        end else begin
          depth_nxt = depth_m1;
          state_nxt = pfxe_pkg::ST_RD_L;
        end
      end
      pfxe_pkg::ST_RD_L: begin
        left_nxt  = ram_rdata;
        state_nxt = pfxe_pkg::ST_EXEC;
      end
      pfxe_pkg::ST_EXEC: begin
        alu_req.start = 1'b1;
        state_nxt     = pfxe_pkg::ST_WAIT;
      end
      pfxe_pkg::ST_WAIT: begin
        if (alu_rsp.done) begin
          push_data_nxt = alu_result;
          if (alu_rsp.div_zero && err_r == pfxe_pkg::STAT_OK) begin
            err_nxt = pfxe_pkg::STAT_DIVZERO;
          end
          state_nxt = pfxe_pkg::ST_PUSH;
        end
      end
      pfxe_pkg::ST_EMIT: begin
        // Hold until the result register is free, then clear the expression
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = right_r;
          out_status_nxt = err_r;
          depth_nxt      = '0;
          err_nxt        = pfxe_pkg::STAT_OK;
          state_nxt      = pfxe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfxe_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall   = (state_r != pfxe_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

FILE: rtl/core/pfxe_ram.sv
// ----------------------------------------------------------------------------
// pfxe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfxe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/pfxe_alu.sv
// ----------------------------------------------------------------------------
// pfxe_alu
// Iterative 32-bit unit around one shared 33-bit adder: add, subtract,
// shift-add multiply and restoring divide with truncation toward zero.
// ----------------------------------------------------------------------------
module pfxe_alu (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfxe_pkg::alu_req_t           req,
  input  logic [pfxe_pkg::DATA_W-1:0]  opd_a,
  input  logic [pfxe_pkg::DATA_W-1:0]  opd_b,
  output pfxe_pkg::alu_rsp_t           rsp,
  output logic [pfxe_pkg::DATA_W-1:0]  result
);

  localparam int W  = pfxe_pkg::DATA_W;
  localparam int CW = $clog2(W);

  pfxe_pkg::alu_phase_t phase_r, phase_nxt;
  pfxe_pkg::alu_op_t    op_r, op_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [W:0]           acc_r, acc_nxt;
  logic [W-1:0]         opa_r, opa_nxt;
  logic [W-1:0]         opb_r, opb_nxt;
  logic                 neg_r, neg_nxt;
  logic                 divz_r, divz_nxt;
  logic [W-1:0]         res_r, res_nxt;

  // Shared adder
  logic [W:0] add_x, add_y, add_sum;
  logic       add_sub;
  logic [W:0] shifted;
  logic [W-1:0] abs_b;

  assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {{W{1'b0}}, add_sub};
  assign shifted = {acc_r[W-1:0], opa_r[W-1]};
  assign abs_b   = opb_r[W-1] ? add_sum[W-1:0] : opb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pfxe_pkg::AP_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    neg_r  <= neg_nxt;
    divz_r <= divz_nxt;
    res_r  <= res_nxt;
  end

  // Steer the shared adder operands from the current phase
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (phase_r)
      pfxe_pkg::AP_IDLE: begin
        add_x   = {1'b0, opd_a};
        add_y   = {1'b0, opd_b};
        add_sub = (req.op == pfxe_pkg::ALU_SUB);
      end
      pfxe_pkg::AP_ABS_A: begin
        add_y   = {1'b0, opa_r};
        add_sub = 1'b1;
      end
      pfxe_pkg::AP_ABS_B: begin
        add_y   = {1'b0, opb_r};
        add_sub = 1'b1;
      end
      pfxe_pkg::AP_ITER: begin
        if (op_r == pfxe_pkg::ALU_MUL) begin
          add_x = {1'b0, acc_r[W-1:0]};
          add_y = {1'b0, opa_r};
        end else begin
          add_x   = shifted;
          add_y   = {1'b0, opb_r};
          add_sub = 1'b1;
        end
      end
      pfxe_pkg::AP_FIX: begin
        add_y   = {1'b0, opa_r};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    neg_nxt   = neg_r;
    divz_nxt  = divz_r;
    res_nxt   = res_r;

    case (phase_r)
      pfxe_pkg::AP_IDLE: begin
        if (req.start) begin
          op_nxt   = req.op;
          opa_nxt  = opd_a;
          opb_nxt  = opd_b;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          divz_nxt = 1'b0;
          neg_nxt  = opd_a[W-1] ^ opd_b[W-1];
          case (req.op)
            pfxe_pkg::ALU_MUL: phase_nxt = pfxe_pkg::AP_ITER;
            pfxe_pkg::ALU_DIV: phase_nxt = pfxe_pkg::AP_ABS_A;
            default: begin
              res_nxt   = add_sum[W-1:0];
              phase_nxt = pfxe_pkg::AP_DONE;
            end
          endcase
        end
      end
      pfxe_pkg::AP_ABS_A: begin
        if (opa_r[W-1]) begin
          opa_nxt = add_sum[W-1:0];
        end
        phase_nxt = pfxe_pkg::AP_ABS_B;
      end
      pfxe_pkg::AP_ABS_B: begin
        opb_nxt = abs_b;
        if (abs_b == '0) begin
          // Divide by zero: flag and return zero
          divz_nxt  = 1'b1;
          res_nxt   = '0;
          phase_nxt = pfxe_pkg::AP_DONE;
        end else begin
          phase_nxt = pfxe_pkg::AP_ITER;
        end
      end
      pfxe_pkg::AP_ITER: begin
        cnt_nxt = cnt_r + 1'b1;
        if (op_r == pfxe_pkg::ALU_MUL) begin
          if (opb_r[0]) begin
            acc_nxt = {1'b0, add_sum[W-1:0]};
          end
          opa_nxt = {opa_r[W-2:0], 1'b0};
          opb_nxt = {1'b0, opb_r[W-1:1]};
        end else begin
          if (!add_sum[W]) begin
            acc_nxt = add_sum;
          end else begin
            acc_nxt = shifted;
          end
          opa_nxt = {opa_r[W-2:0], ~add_sum[W]};
        end
        if (cnt_r == CW'(W - 1)) begin
          phase_nxt = pfxe_pkg::AP_FIX;
        end
      end
      pfxe_pkg::AP_FIX: begin
        if (op_r == pfxe_pkg::ALU_MUL) begin
          res_nxt = acc_r[W-1:0];
        end else begin
          res_nxt = neg_r ? add_sum[W-1:0] : opa_r;
        end
        phase_nxt = pfxe_pkg::AP_DONE;
      end
      pfxe_pkg::AP_DONE: begin
        phase_nxt = pfxe_pkg::AP_IDLE;
      end
      default: begin
        phase_nxt = pfxe_pkg::AP_IDLE;
      end
    endcase
  end

  assign rsp.done     = (phase_r == pfxe_pkg::AP_DONE);
  assign rsp.div_zero = divz_r;
  assign result       = res_r;

endmodule

FILE: rtl/core/pfxe_chk.sv
// ----------------------------------------------------------------------------
// pfxe_chk
// Port-level checks of the postfix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_macros.svh"

module pfxe_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_char_code,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [31:0] out_value,
  input logic [1:0]  out_status
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  `PFXE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_status), "result changed while stalled")

  `PFXE_ASSERT_NEXT(a_digit_busy, in_xfer && in_char_code >= pfxe_pkg::CH_ZERO && in_char_code <= pfxe_pkg::CH_NINE, in_stall, "digit push did not occupy the block")

  `PFXE_ASSERT_NEXT(a_high_ignored, in_xfer && in_char_code[7], !in_stall, "non-ASCII character was not dropped")

  `PFXE_ASSERT_NEXT(a_term_busy, in_xfer && in_char_code == pfxe_pkg::CH_CLOSE, in_stall, "terminator did not start a pop")

endmodule

bind postfix_expression_evaluator pfxe_chk u_pfxe_chk (.*);

FILE: tb/postfix_expression_evaluator_test.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_test
// Self-checking bench for the reverse Polish character evaluator.
// ----------------------------------------------------------------------------
// A character stream is built up front: a short directed part that hits the
// stack and status corner cases, then mostly well-formed random expressions,
// with broken sequences, stray bytes and a few stack-filling runs mixed in.
// A clocked driver feeds the stream through the valid/stall handshake, and
// every accepted character also goes through a behavioral evaluator that
// queues the expected result for each ')'. A clocked monitor compares every
// result transfer field by field with the oldest queued result. Idling moves
// through three phases: a busy receiver with a rarely idle sender, then the
// reverse, then full speed on both sides.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_test;
  import pfxe_pkg::*;

  localparam int TARGET_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 60;
  localparam int DEEP_RUNS    = 3;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } rpn_result_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [7:0]        in_char_code = 8'h00;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic signed [31:0] out_value;
  logic [1:0]        out_status;

  // stimulus and scoreboard
  logic [7:0]  char_queue[$];
  rpn_result_t pending_results[$];
  int          n_items;
  int          total_chars;
  int          chars_sent;
  int          results_checked;
  int          error_count;
  int          cycle_count;
  int          status_seen[4];

  // behavioral copy of the evaluator state
  logic [31:0] eval_stack[STACK_DEPTH_DEF];
  int unsigned eval_depth;
  logic [1:0]  eval_status;

  postfix_expression_evaluator u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_status   (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Evaluator
  // --------------------------------------------------------------------------

  // Keep only the first error of an expression.
  function automatic void flag_error(input logic [1:0] code);
    if (eval_status == STAT_OK) eval_status = code;
  endfunction

  // A push on a full stack drops the value.
  function automatic void push_operand(input logic [31:0] v);
    if (eval_depth >= STACK_DEPTH_DEF) begin
      flag_error(STAT_OVERFLOW);
    end else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endfunction

  // A pop on an empty stack reads as zero.
  function automatic logic [31:0] pop_operand();
    if (eval_depth == 0) begin
      flag_error(STAT_UNDERFLOW);
      return '0;
    end
    eval_depth--;
    return eval_stack[eval_depth];
  endfunction

  // Work on magnitudes so that the most negative value over minus one wraps
  // back to itself instead of trapping.
  function automatic logic [31:0] quotient_toward_zero(input logic [31:0] num,
                                                       input logic [31:0] den);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] q;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    if (mag_d == 0) begin
      flag_error(STAT_DIVZERO);
      return '0;
    end
    q = mag_n / mag_d;
    return (num[31] != den[31]) ? -q : q;
  endfunction

  function automatic bit is_meaningful(input logic [7:0] ch);
    return (ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_PLUS || ch == CH_MINUS ||
           ch == CH_STAR || ch == CH_SLASH || ch == CH_CLOSE;
  endfunction

  // Advance the evaluator by one character; returns 1 when ')' emits a result.
  function automatic bit evaluate_char(input logic [7:0] ch, output rpn_result_t res);
    logic [31:0] rhs;
    logic [31:0] lhs;
    logic [31:0] acc;
    res = '0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      push_operand(32'(ch - CH_ZERO));
      return 1'b0;
    end
    if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH) begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (ch)
        CH_PLUS:  acc = lhs + rhs;
        CH_MINUS: acc = lhs - rhs;
        CH_STAR:  acc = lhs * rhs;
        default:  acc = quotient_toward_zero(lhs, rhs);
      endcase
      push_operand(acc);
      return 1'b0;
    end
    if (ch == CH_CLOSE) begin
      res.value   = pop_operand();
      res.status  = eval_status;
      eval_depth  = 0;
      eval_status = STAT_OK;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Only characters that the block acts on count toward the item target.
  function automatic void queue_char(input logic [7:0] ch);
    char_queue.push_back(ch);
    if (is_meaningful(ch)) n_items++;
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] random_ignored();
    logic [7:0] ch;
    ch = 8'($urandom_range(255));
    while (is_meaningful(ch)) ch = 8'($urandom_range(255));
    return ch;
  endfunction

  // Three idling phases, switched by how far the stream has gone.
  function automatic int idle_phase();
    return (total_chars == 0) ? 0 : (chars_sent * 3) / total_chars;
  endfunction

  function automatic int send_idle_pct();
    case (idle_phase())
      0:       return 15;
      1:       return 74;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_phase())
      0:       return 74;
      1:       return 15;
      default: return 0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one transfer per accepted character
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rpn_result_t res;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_char_code <= 8'h00;
    end else begin
      // The character on the port moved this edge: predict its outcome.
      if (in_valid && !in_stall) begin
        if (evaluate_char(in_char_code, res)) pending_results.push_back(res);
        chars_sent++;
      end
      // Hold a stalled character; otherwise present the next one or idle.
      if (!in_valid || !in_stall) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          in_valid     <= 1'b1;
          in_char_code <= char_queue.pop_front();
        end else begin
          in_valid     <= 1'b0;
          in_char_code <= 8'($urandom_range(255));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rpn_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: value %0d status %0d",
                 out_value, out_status);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          status_seen[want.status]++;
          if (out_value !== want.value) begin
            $error("value mismatch: expected %0d, got %0d", want.value, out_value);
            error_count++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stream build, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int kind;
    int n_operands;
    int placed;
    int depth;
    int deep_done;

    n_items         = 0;
    chars_sent      = 0;
    results_checked = 0;
    error_count     = 0;
    deep_done       = 0;
    eval_depth      = 0;
    eval_status     = STAT_OK;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Terminator on an empty stack reports underflow.
    queue_char(CH_CLOSE);
    // Divide by zero, with both digit extremes.
    queue_text("90/)");
    // Operator with one operand: the left pop underflows.
    queue_text("73-+)");
    // Negative quotient truncates toward zero: -7 / 2 gives -3.
    queue_text("07-2/)");
    // Stray bytes, top bit set and clear, dropped by the block.
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char(8'h28);
    queue_char(8'h3A);
    // Build 8^10 * 2 = 0x80000000, then divide by -1: wraps to itself.
    queue_char(CH_ZERO + 8'd8);
    repeat (9) queue_text("8*");
    queue_text("2*01-/)");

    while (n_items < TARGET_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        // Well-formed expression, random operands and operators.
        n_operands = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        placed = 0;
        depth  = 0;
        while (placed < n_operands || depth > 1) begin
          if (placed < n_operands && (depth < 2 || $urandom_range(1) == 0)) begin
            queue_char(random_digit());
            placed++;
            depth++;
          end else begin
            queue_char(random_op());
            depth--;
          end
          if ($urandom_range(29) == 0) queue_char(random_ignored());
        end
        queue_char(CH_CLOSE);
      end else if (kind < 85) begin
        // Broken sequence: unbalanced operators, early or missing terminator.
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(2))
            0:       queue_char(random_digit());
            1:       queue_char(random_op());
            default: queue_char(CH_CLOSE);
          endcase
        end
        if ($urandom_range(1) == 0) queue_char(CH_CLOSE);
      end else if (kind < 97 || deep_done >= DEEP_RUNS) begin
        // Raw bytes over the full range.
        repeat ($urandom_range(1, 4)) queue_char(8'($urandom_range(255)));
      end else begin
        // Fill the stack to just below, at or past its depth.
        repeat (STACK_DEPTH_DEF - 3 + $urandom_range(6)) queue_char(random_digit());
        repeat ($urandom_range(3)) queue_char(random_op());
        queue_char(CH_CLOSE);
        deep_done++;
      end
    end
    total_chars = char_queue.size();

    // Hold reset, then release it for good.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every character sent, every expected result taken, then a tail
    // long enough to catch a late extra result after the slowest operator.
    while (chars_sent < total_chars) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d characters (%0d acted on) and %0d checked results;",
             total_chars, n_items, results_checked);
    $display("result statuses: %0d clean, %0d overflow, %0d underflow, %0d divide by zero",
             status_seen[STAT_OK], status_seen[STAT_OVERFLOW],
             status_seen[STAT_UNDERFLOW], status_seen[STAT_DIVZERO]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
